// ===== design/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg: shared widths and types for the segment intersection pipeline
// Coordinate, product, quotient and point widths; stage payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sip_pkg;

  localparam int CW        = 16;              // coordinate width
  localparam int FB        = 16;              // fraction bits of the point
  localparam int OW        = 32;              // point output width
  localparam int DW        = CW + 1;          // difference width
  localparam int PW        = 2 * DW;          // product width
  localparam int XW        = PW + 1;          // den / num width (signed)
  localparam int MW        = XW;              // magnitude width of den / num
  localparam int NW        = DW + MW + FB;    // dividend width
  localparam int QB        = CW + FB + 2;     // quotient bits kept
  // signed point width before trim; never narrower than the output
  localparam int PSW       = (QB + 2 > OW) ? QB + 2 : OW;
  localparam int FRONT_ST  = 5;
  localparam int BACK_ST   = 2;
  localparam int NS        = FRONT_ST + QB + BACK_ST;

  typedef struct packed {
    logic signed [CW-1:0] a0x;
    logic signed [CW-1:0] a0y;
    logic signed [CW-1:0] a1x;
    logic signed [CW-1:0] a1y;
    logic signed [CW-1:0] b0x;
    logic signed [CW-1:0] b0y;
    logic signed [CW-1:0] b1x;
    logic signed [CW-1:0] b1y;
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic            miss;
    logic            neg_x;
    logic            neg_y;
    logic [MW-1:0]   den;
    logic [MW-1:0]   rem_x;
    logic [MW-1:0]   rem_y;
    logic [QB-1:0]   nq_x;
    logic [QB-1:0]   nq_y;
  } div_t;

endpackage

`default_nettype wire

// ===== design/sip_if.sv =====
// ----------------------------------------------------------------------------
// sip_if: request channels of the segment intersection block
// Segment pair channel and intersection point channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sip_seg_if;
  logic                          valid;
  logic                          ready;
  logic signed [sip_pkg::CW-1:0] seg_a_start_x;
  logic signed [sip_pkg::CW-1:0] seg_a_start_y;
  logic signed [sip_pkg::CW-1:0] seg_a_end_x;
  logic signed [sip_pkg::CW-1:0] seg_a_end_y;
  logic signed [sip_pkg::CW-1:0] seg_b_start_x;
  logic signed [sip_pkg::CW-1:0] seg_b_start_y;
  logic signed [sip_pkg::CW-1:0] seg_b_end_x;
  logic signed [sip_pkg::CW-1:0] seg_b_end_y;

  modport source(output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                 seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
                 input ready);
  modport sink(input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
               seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
               output ready);
endinterface

interface sip_pt_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic signed [sip_pkg::OW-1:0] point_x;
  logic signed [sip_pkg::OW-1:0] point_y;

  modport source(output valid, hit, point_x, point_y, input ready);
  modport sink(input valid, hit, point_x, point_y, output ready);
endinterface

`default_nettype wire

// ===== design/segment_intersection_point.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_point: 2D segment pair intersection in Q.16
// Denominator/numerator cross products, a chain of restoring divide cells and
// a bounds test; one segment pair per request, one point per request.
// ----------------------------------------------------------------------------
// Stages: 5 setup stages, 34 divide cells (one quotient bit each) and
//   2 assembly stages between an accepted request and its point.
// Throughput: one request per cycle while unstalled; each stage feeds the next.
// Stalls collapse bubbles: a stage loads whenever it or the stage ahead frees.
// Reset (rst, synchronous, active high) clears every stage valid; no point
//   is shown until new requests arrive. Datapath registers are not reset.
`default_nettype none

module segment_intersection_point (
  input  wire logic  clk,
  input  wire logic  rst,
  sip_seg_if.sink    segs,
  sip_pt_if.source   point
);

  logic [sip_pkg::NS-1:0] vld;        // stage holds a live request
  logic [sip_pkg::NS-1:0] vld_next;
  logic [sip_pkg::NS-1:0] en;         // stage may load this cycle
  sip_pkg::seg_t          seg_in;
  sip_pkg::div_t          chain [sip_pkg::QB+1];

  // Ready travels backward: a stage frees if it is empty or the next one loads.
  always_comb begin
    en[sip_pkg::NS-1] = !vld[sip_pkg::NS-1] || point.ready;
    for (int i = sip_pkg::NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // Advance the valid chain; a stage that loads takes its predecessor's valid.
  always_comb begin
    vld_next = vld;
    if (en[0]) begin
      vld_next[0] = segs.valid;
    end
    for (int i = 1; i < sip_pkg::NS; i++) begin
      if (en[i]) begin
        vld_next[i] = vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign segs.ready  = en[0];
  assign point.valid = vld[sip_pkg::NS-1];

  always_comb begin
    seg_in.a0x = segs.seg_a_start_x;
    seg_in.a0y = segs.seg_a_start_y;
    seg_in.a1x = segs.seg_a_end_x;
    seg_in.a1y = segs.seg_a_end_y;
    seg_in.b0x = segs.seg_b_start_x;
    seg_in.b0y = segs.seg_b_start_y;
    seg_in.b1x = segs.seg_b_end_x;
    seg_in.b1y = segs.seg_b_end_y;
  end

  // Cross products and divide setup.
  sip_front u_front (
    .clk  (clk),
    .en   (en[sip_pkg::FRONT_ST-1:0]),
    .seg  (seg_in),
    .dout (chain[0])
  );

  // One quotient bit per cell, most significant first.
  for (genvar c = 0; c < sip_pkg::QB; c++) begin : g_cell
    sip_div_cell u_cell (
      .clk  (clk),
      .en   (en[sip_pkg::FRONT_ST + c]),
      .din  (chain[c]),
      .dout (chain[c+1])
    );
  end

  // Signed point, bounds test, output register.
  sip_back u_back (
    .clk     (clk),
    .en      (en[sip_pkg::NS-1:sip_pkg::NS-sip_pkg::BACK_ST]),
    .din     (chain[sip_pkg::QB]),
    .hit     (point.hit),
    .point_x (point.point_x),
    .point_y (point.point_y)
  );

endmodule

`default_nettype wire

// ===== design/sip_front.sv =====
// ----------------------------------------------------------------------------
// sip_front: cross products and dividend setup
// Five stages: deltas, products, den/num, scaled numerators, divide setup.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_front (
  input  wire logic                              clk,
  input  wire logic [sip_pkg::FRONT_ST-1:0]      en,
  input  wire sip_pkg::seg_t                     seg,
  output sip_pkg::div_t                          dout
);

  // stage 1
  sip_pkg::seg_t                  seg1;
  logic signed [sip_pkg::DW-1:0]  dax1, day1, dbx1, dby1, dx1, dy1;
  // stage 2
  sip_pkg::seg_t                  seg2;
  logic signed [sip_pkg::DW-1:0]  dax2, day2;
  logic signed [sip_pkg::PW-1:0]  p_ad, p_bc, p_nd, p_nc;
  // stage 3
  sip_pkg::seg_t                  seg3;
  logic [sip_pkg::MW-1:0]         mden3, mnum3;
  logic [sip_pkg::DW-1:0]         mdax3, mday3;
  logic                           nx3, ny3, zero3;
  // stage 4
  sip_pkg::seg_t                  seg4;
  logic [sip_pkg::MW-1:0]         mden4;
  logic [sip_pkg::DW+sip_pkg::MW-1:0] mx4, my4;
  logic                           nx4, ny4, zero4;

  logic signed [sip_pkg::XW-1:0]  den_w, num_w;
  logic [sip_pkg::NW-1:0]         nx_w, ny_w;
  logic                           ovf_x, ovf_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      seg1 <= seg;
      dax1 <= sip_pkg::DW'(seg.a1x) - sip_pkg::DW'(seg.a0x);
      day1 <= sip_pkg::DW'(seg.a1y) - sip_pkg::DW'(seg.a0y);
      dbx1 <= sip_pkg::DW'(seg.b1x) - sip_pkg::DW'(seg.b0x);
      dby1 <= sip_pkg::DW'(seg.b1y) - sip_pkg::DW'(seg.b0y);
      dx1  <= sip_pkg::DW'(seg.b0x) - sip_pkg::DW'(seg.a0x);
      dy1  <= sip_pkg::DW'(seg.b0y) - sip_pkg::DW'(seg.a0y);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      seg2 <= seg1;
      dax2 <= dax1;
      day2 <= day1;
      p_ad <= sip_pkg::PW'(dax1) * sip_pkg::PW'(dby1);
      p_bc <= sip_pkg::PW'(day1) * sip_pkg::PW'(dbx1);
      p_nd <= sip_pkg::PW'(dx1) * sip_pkg::PW'(dby1);
      p_nc <= sip_pkg::PW'(dy1) * sip_pkg::PW'(dbx1);
    end
  end

  always_comb begin
    den_w = sip_pkg::XW'(p_ad) - sip_pkg::XW'(p_bc);
    num_w = sip_pkg::XW'(p_nd) - sip_pkg::XW'(p_nc);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      seg3  <= seg2;
      mden3 <= den_w[sip_pkg::XW-1] ? sip_pkg::MW'(-den_w) : sip_pkg::MW'(den_w);
      mnum3 <= num_w[sip_pkg::XW-1] ? sip_pkg::MW'(-num_w) : sip_pkg::MW'(num_w);
      mdax3 <= dax2[sip_pkg::DW-1] ? sip_pkg::DW'(-dax2) : sip_pkg::DW'(dax2);
      mday3 <= day2[sip_pkg::DW-1] ? sip_pkg::DW'(-day2) : sip_pkg::DW'(day2);
      nx3   <= dax2[sip_pkg::DW-1] ^ num_w[sip_pkg::XW-1] ^ den_w[sip_pkg::XW-1];
      ny3   <= day2[sip_pkg::DW-1] ^ num_w[sip_pkg::XW-1] ^ den_w[sip_pkg::XW-1];
      zero3 <= (den_w == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      seg4  <= seg3;
      mden4 <= mden3;
      mx4   <= (sip_pkg::DW+sip_pkg::MW)'(mdax3) * (sip_pkg::DW+sip_pkg::MW)'(mnum3);
      my4   <= (sip_pkg::DW+sip_pkg::MW)'(mday3) * (sip_pkg::DW+sip_pkg::MW)'(mnum3);
      nx4   <= nx3;
      ny4   <= ny3;
      zero4 <= zero3;
    end
  end

  // quotient beyond QB bits can never land inside a bound: flag as a miss
  always_comb begin
    nx_w  = {mx4, {sip_pkg::FB{1'b0}}};
    ny_w  = {my4, {sip_pkg::FB{1'b0}}};
    ovf_x = sip_pkg::MW'(nx_w[sip_pkg::NW-1:sip_pkg::QB]) >= mden4;
    ovf_y = sip_pkg::MW'(ny_w[sip_pkg::NW-1:sip_pkg::QB]) >= mden4;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dout.seg   <= seg4;
      dout.miss  <= zero4 | ovf_x | ovf_y;
      dout.neg_x <= nx4;
      dout.neg_y <= ny4;
      dout.den   <= mden4;
      dout.rem_x <= sip_pkg::MW'(nx_w[sip_pkg::NW-1:sip_pkg::QB]);
      dout.rem_y <= sip_pkg::MW'(ny_w[sip_pkg::NW-1:sip_pkg::QB]);
      dout.nq_x  <= nx_w[sip_pkg::QB-1:0];
      dout.nq_y  <= ny_w[sip_pkg::QB-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/sip_div_cell.sv =====
// ----------------------------------------------------------------------------
// sip_div_cell: one restoring division step for both axes
// Shift in one dividend bit, trial-subtract the divisor, shift in a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_div_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire sip_pkg::div_t din,
  output sip_pkg::div_t      dout
);

  logic [sip_pkg::MW:0] tx, ty;
  logic                 gx, gy;
  sip_pkg::div_t        dout_next;

  always_comb begin
    tx = {din.rem_x, din.nq_x[sip_pkg::QB-1]};
    ty = {din.rem_y, din.nq_y[sip_pkg::QB-1]};
    gx = tx >= {1'b0, din.den};
    gy = ty >= {1'b0, din.den};
    dout_next       = din;
    dout_next.rem_x = gx ? sip_pkg::MW'(tx - {1'b0, din.den}) : sip_pkg::MW'(tx);
    dout_next.rem_y = gy ? sip_pkg::MW'(ty - {1'b0, din.den}) : sip_pkg::MW'(ty);
    dout_next.nq_x  = {din.nq_x[sip_pkg::QB-2:0], gx};
    dout_next.nq_y  = {din.nq_y[sip_pkg::QB-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/sip_back.sv =====
// ----------------------------------------------------------------------------
// sip_back: point assembly and bounds test
// Apply sign, add the start point, test both segments' ranges, register result.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_back (
  input  wire logic                          clk,
  input  wire logic [sip_pkg::BACK_ST-1:0]   en,
  input  wire sip_pkg::div_t                 din,
  output logic                               hit,
  output logic signed [sip_pkg::OW-1:0]      point_x,
  output logic signed [sip_pkg::OW-1:0]      point_y
);

  sip_pkg::seg_t                  seg1;
  logic                           miss1;
  logic signed [sip_pkg::PSW-1:0] px1, py1;
  logic signed [sip_pkg::PSW-1:0] qx, qy, bx, by;
  logic                           in_all;

  function automatic logic in_rng(input logic signed [sip_pkg::PSW-1:0] p,
                                  input logic signed [sip_pkg::CW-1:0] e0,
                                  input logic signed [sip_pkg::CW-1:0] e1);
    logic signed [sip_pkg::PSW-1:0] lo, hi;
    lo = sip_pkg::PSW'((e0 < e1) ? e0 : e1) <<< sip_pkg::FB;
    hi = sip_pkg::PSW'((e0 < e1) ? e1 : e0) <<< sip_pkg::FB;
    return (p >= lo) && (p <= hi);
  endfunction

  always_comb begin
    qx = $signed(sip_pkg::PSW'(din.nq_x));
    qy = $signed(sip_pkg::PSW'(din.nq_y));
    bx = sip_pkg::PSW'(din.seg.a0x) <<< sip_pkg::FB;
    by = sip_pkg::PSW'(din.seg.a0y) <<< sip_pkg::FB;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      seg1  <= din.seg;
      miss1 <= din.miss;
      px1   <= bx + (din.neg_x ? -qx : qx);
      py1   <= by + (din.neg_y ? -qy : qy);
    end
  end

  always_comb begin
    in_all = in_rng(px1, seg1.a0x, seg1.a1x) && in_rng(py1, seg1.a0y, seg1.a1y) &&
             in_rng(px1, seg1.b0x, seg1.b1x) && in_rng(py1, seg1.b0y, seg1.b1y);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hit     <= !miss1 && in_all;
      point_x <= (!miss1 && in_all) ? px1[sip_pkg::OW-1:0] : '0;
      point_y <= (!miss1 && in_all) ? py1[sip_pkg::OW-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/sip_chk.sv =====
// ----------------------------------------------------------------------------
// sip_chk: port checks for the segment intersection block
// Output hold under stall, zero point on a miss, quiet output after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sip_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          hit,
  input wire logic signed [sip_pkg::OW-1:0] point_x,
  input wire logic signed [sip_pkg::OW-1:0] point_y
);

  // hold a stalled point
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(point_x)
                                && $stable(point_y))
    else $error("stalled point changed");

  // drop the point on a miss
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> point_x == '0 && point_y == '0)
    else $error("miss carries a nonzero point");

  // no point right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("point shown after reset");

endmodule

bind segment_intersection_point sip_chk u_sip_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (point.valid),
  .out_ready (point.ready),
  .hit       (point.hit),
  .point_x   (point.point_x),
  .point_y   (point.point_y)
);

`default_nettype wire
